/* src/lsw_pkg.sv */
// shared constants for the line segment window clipper
`timescale 1ns / 1ps

package lsw_pkg;

    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RIGHT  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTTOM = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOP    = 3'd3;

endpackage

/* src/lsw_setup.sv */
// first stage: deltas, per-axis entry and exit fractions, trivial rejects
`timescale 1ns / 1ps

module lsw_setup #(
    parameter int W = 12
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] x1,
    input  logic signed [W-1:0] y1,
    input  logic signed [W-1:0] x2,
    input  logic signed [W-1:0] y2,
    input  logic signed [W-1:0] win_l,
    input  logic signed [W-1:0] win_r,
    input  logic signed [W-1:0] win_b,
    input  logic signed [W-1:0] win_t,
    output logic signed [W-1:0] x1_reg,
    output logic signed [W-1:0] y1_reg,
    output logic signed [W:0]   dx_reg,
    output logic signed [W:0]   dy_reg,
    output logic signed [W:0]   xen_reg,
    output logic signed [W:0]   xex_reg,
    output logic        [W:0]   xden_reg,
    output logic signed [W:0]   yen_reg,
    output logic signed [W:0]   yex_reg,
    output logic        [W:0]   yden_reg,
    output logic                rej_reg
);

    logic signed [W:0] ex1, ey1, ex2, ey2, el, er, eb, et;
    logic signed [W:0] dx, dy;
    logic        [W:0] adx, ady;
    logic signed [W:0] xen_next, xex_next, yen_next, yex_next;
    logic        [W:0] xden_next, yden_next;
    logic              rej_next;

    assign ex1 = (W+1)'(x1);
    assign ey1 = (W+1)'(y1);
    assign ex2 = (W+1)'(x2);
    assign ey2 = (W+1)'(y2);
    assign el  = (W+1)'(win_l);
    assign er  = (W+1)'(win_r);
    assign eb  = (W+1)'(win_b);
    assign et  = (W+1)'(win_t);
    assign dx  = ex2 - ex1;
    assign dy  = ey2 - ey1;
    assign adx = dx[W] ? unsigned'(-dx) : unsigned'(dx);
    assign ady = dy[W] ? unsigned'(-dy) : unsigned'(dy);

    always_comb
    begin
        if (dx == '0)
        begin
            xen_next  = '0;
            xex_next  = (W+1)'(1);
            xden_next = (W+1)'(1);
        end
        else if (dx[W])
        begin
            xen_next  = ex1 - er;
            xex_next  = ex1 - el;
            xden_next = adx;
        end
        else
        begin
            xen_next  = el - ex1;
            xex_next  = er - ex1;
            xden_next = adx;
        end
        if (dy == '0)
        begin
            yen_next  = '0;
            yex_next  = (W+1)'(1);
            yden_next = (W+1)'(1);
        end
        else if (dy[W])
        begin
            yen_next  = ey1 - et;
            yex_next  = ey1 - eb;
            yden_next = ady;
        end
        else
        begin
            yen_next  = eb - ey1;
            yex_next  = et - ey1;
            yden_next = ady;
        end
        rej_next = (win_l > win_r) || (win_b > win_t)
                   || ((dx == '0) && ((x1 < win_l) || (x1 > win_r)))
                   || ((dy == '0) && ((y1 < win_b) || (y1 > win_t)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= x1;
            y1_reg   <= y1;
            dx_reg   <= dx;
            dy_reg   <= dy;
            xen_reg  <= xen_next;
            xex_reg  <= xex_next;
            xden_reg <= xden_next;
            yen_reg  <= yen_next;
            yex_reg  <= yex_next;
            yden_reg <= yden_next;
            rej_reg  <= rej_next;
        end
    end

endmodule

/* src/lsw_frac.sv */
// three stages: pick u1 and u2, clamp and compare, form dividends
`timescale 1ns / 1ps

module lsw_frac #(
    parameter int W = 12
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   x1,
    input  logic signed [W-1:0]   y1,
    input  logic signed [W:0]     dx,
    input  logic signed [W:0]     dy,
    input  logic signed [W:0]     xen,
    input  logic signed [W:0]     xex,
    input  logic        [W:0]     xden,
    input  logic signed [W:0]     yen,
    input  logic signed [W:0]     yex,
    input  logic        [W:0]     yden,
    input  logic                  rej,
    output logic signed [W-1:0]   bx_reg,
    output logic signed [W-1:0]   by_reg,
    output logic        [2*W+2:0] nx1_reg,
    output logic        [2*W+2:0] ny1_reg,
    output logic        [2*W+2:0] nx2_reg,
    output logic        [2*W+2:0] ny2_reg,
    output logic        [3:0]     neg_reg,
    output logic        [W+1:0]   d1_reg,
    output logic        [W+1:0]   d2_reg,
    output logic                  rej_reg
);

    // stage a: larger entry, smaller exit
    logic signed [2*W+2:0] pa, pb, pc, pd;
    logic signed [W:0]     en_reg, ex_reg, dxa_reg, dya_reg;
    logic        [W:0]     end_reg, exd_reg;
    logic signed [W-1:0]   xa_reg, ya_reg;
    logic                  reja_reg;

    assign pa = xen * $signed({1'b0, yden});
    assign pb = yen * $signed({1'b0, xden});
    assign pc = xex * $signed({1'b0, yden});
    assign pd = yex * $signed({1'b0, xden});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            en_reg   <= (pa > pb) ? xen : yen;
            end_reg  <= (pa > pb) ? xden : yden;
            ex_reg   <= (pc < pd) ? xex : yex;
            exd_reg  <= (pc < pd) ? xden : yden;
            dxa_reg  <= dx;
            dya_reg  <= dy;
            xa_reg   <= x1;
            ya_reg   <= y1;
            reja_reg <= rej;
        end
    end

    // stage b: clamp to [0,1] and check u1 <= u2
    logic signed [W:0]     u1n, u2n, n1_reg, n2_reg;
    logic        [W:0]     u1d, u2d, n1d_reg, n2d_reg;
    logic signed [2*W+2:0] pe, pf;
    logic signed [W:0]     dxb_reg, dyb_reg;
    logic signed [W-1:0]   xb_reg, yb_reg;
    logic                  rejb_reg;

    always_comb
    begin
        if (en_reg[W])
        begin
            u1n = '0;
            u1d = (W+1)'(1);
        end
        else
        begin
            u1n = en_reg;
            u1d = end_reg;
        end
        if (($signed({ex_reg[W], ex_reg}) > $signed({1'b0, exd_reg})))
        begin
            u2n = (W+1)'(1);
            u2d = (W+1)'(1);
        end
        else
        begin
            u2n = ex_reg;
            u2d = exd_reg;
        end
    end

    assign pe = u1n * $signed({1'b0, u2d});
    assign pf = u2n * $signed({1'b0, u1d});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= u1n;
            n1d_reg  <= u1d;
            n2_reg   <= u2n;
            n2d_reg  <= u2d;
            dxb_reg  <= dxa_reg;
            dyb_reg  <= dya_reg;
            xb_reg   <= xa_reg;
            yb_reg   <= ya_reg;
            rejb_reg <= reja_reg || (pe > pf);
        end
    end

    // stage c: dividend 2*n*d + den as sign and magnitude
    logic signed [2*W+1:0] px1, py1, px2, py2;
    logic signed [2*W+3:0] sx1, sy1, sx2, sy2;
    logic signed [2*W+3:0] mx1, my1, mx2, my2;

    assign px1 = n1_reg * dxb_reg;
    assign py1 = n1_reg * dyb_reg;
    assign px2 = n2_reg * dxb_reg;
    assign py2 = n2_reg * dyb_reg;
    assign sx1 = $signed({px1[2*W+1], px1, 1'b0}) + $signed({{(W+3){1'b0}}, n1d_reg});
    assign sy1 = $signed({py1[2*W+1], py1, 1'b0}) + $signed({{(W+3){1'b0}}, n1d_reg});
    assign sx2 = $signed({px2[2*W+1], px2, 1'b0}) + $signed({{(W+3){1'b0}}, n2d_reg});
    assign sy2 = $signed({py2[2*W+1], py2, 1'b0}) + $signed({{(W+3){1'b0}}, n2d_reg});
    assign mx1 = sx1[2*W+3] ? -sx1 : sx1;
    assign my1 = sy1[2*W+3] ? -sy1 : sy1;
    assign mx2 = sx2[2*W+3] ? -sx2 : sx2;
    assign my2 = sy2[2*W+3] ? -sy2 : sy2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx1_reg <= mx1[2*W+2:0];
            ny1_reg <= my1[2*W+2:0];
            nx2_reg <= mx2[2*W+2:0];
            ny2_reg <= my2[2*W+2:0];
            neg_reg <= {sy2[2*W+3], sx2[2*W+3], sy1[2*W+3], sx1[2*W+3]};
            d1_reg  <= {n1d_reg, 1'b0};
            d2_reg  <= {n2d_reg, 1'b0};
            bx_reg  <= xb_reg;
            by_reg  <= yb_reg;
            rej_reg <= rejb_reg;
        end
    end

endmodule

/* src/lsw_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module lsw_div #(
    parameter int W = 12
) (
    input  logic           clk,
    input  logic           en,
    input  logic [2*W+2:0] num,
    input  logic [W+1:0]   den,
    output logic [W+1:0]   quo,
    output logic           rem_nz
);

    localparam int QW = W + 2;

    logic [W+1:0]  rem_reg [1:QW];
    logic [QW-1:0] low_reg [1:QW];
    logic [QW-1:0] quo_reg [1:QW];
    logic [W+1:0]  den_reg [1:QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [W+1:0]  r_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [W+1:0]  den_in;
        logic [W+2:0]  trial;
        logic          fit;

        if (k == 0)
        begin : g_first
            assign r_in   = {1'b0, num[2*W+2:QW]};
            assign low_in = num[QW-1:0];
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign r_in   = rem_reg[k];
            assign low_in = low_reg[k];
            assign quo_in = quo_reg[k];
            assign den_in = den_reg[k];
        end

        assign trial = {r_in, low_in[QW-1]};
        assign fit   = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= fit ? (W+2)'(trial - {1'b0, den_in}) : trial[W+1:0];
                low_reg[k+1] <= {low_in[QW-2:0], 1'b0};
                quo_reg[k+1] <= {quo_in[QW-2:0], fit};
                den_reg[k+1] <= den_in;
            end
        end
    end

    assign quo    = quo_reg[QW];
    assign rem_nz = |rem_reg[QW];

endmodule

/* src/line_segment_window_clipper_core.sv */
// path: setup stage, fraction stages, divider stages, then the output register
// throughput: one segment per cycle while the output is not stalled; the four divider lanes are fully pipelined
// a stalled output holds the whole pipeline, bubbles are not squeezed out
// reset: clears the valid bits and restores the full-range window
// config port always ready, writes take effect for items accepted afterward
`timescale 1ns / 1ps

module line_segment_window_clipper_core #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    // visible
    output logic                                m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = ((4*W+7)/8)*8;
    localparam int QW = W + 2;
    localparam int NV = QW + 5;
    localparam int SW = 2*W + 5;

    logic signed [W-1:0] left_reg, right_reg, bottom_reg, top_reg;
    logic [NV:1]         vld_reg;
    logic                en;

    assign cfg_ready     = 1'b1;
    assign en            = !vld_reg[NV] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= {1'b1, {(W-1){1'b0}}};
            right_reg  <= {1'b0, {(W-1){1'b1}}};
            bottom_reg <= {1'b1, {(W-1){1'b0}}};
            top_reg    <= {1'b0, {(W-1){1'b1}}};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lsw_pkg::REG_LEFT:   left_reg   <= cfg_data;
                lsw_pkg::REG_RIGHT:  right_reg  <= cfg_data;
                lsw_pkg::REG_BOTTOM: bottom_reg <= cfg_data;
                lsw_pkg::REG_TOP:    top_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NV-1:1], s_axis_tvalid};
        end
    end

    // setup stage
    logic signed [W-1:0] s1_x1, s1_y1;
    logic signed [W:0]   s1_dx, s1_dy, s1_xen, s1_xex, s1_yen, s1_yex;
    logic        [W:0]   s1_xden, s1_yden;
    logic                s1_rej;

    lsw_setup #(.W(W)) u_setup (
        .clk      (clk),
        .en       (en),
        .x1       (s_axis_tdata[W-1:0]),
        .y1       (s_axis_tdata[2*W-1:W]),
        .x2       (s_axis_tdata[3*W-1:2*W]),
        .y2       (s_axis_tdata[4*W-1:3*W]),
        .win_l    (left_reg),
        .win_r    (right_reg),
        .win_b    (bottom_reg),
        .win_t    (top_reg),
        .x1_reg   (s1_x1),
        .y1_reg   (s1_y1),
        .dx_reg   (s1_dx),
        .dy_reg   (s1_dy),
        .xen_reg  (s1_xen),
        .xex_reg  (s1_xex),
        .xden_reg (s1_xden),
        .yen_reg  (s1_yen),
        .yex_reg  (s1_yex),
        .yden_reg (s1_yden),
        .rej_reg  (s1_rej)
    );

    // fraction stages
    logic signed [W-1:0] f_bx, f_by;
    logic [2*W+2:0]      f_nx1, f_ny1, f_nx2, f_ny2;
    logic [3:0]          f_neg;
    logic [W+1:0]        f_d1, f_d2;
    logic                f_rej;

    lsw_frac #(.W(W)) u_frac (
        .clk     (clk),
        .en      (en),
        .x1      (s1_x1),
        .y1      (s1_y1),
        .dx      (s1_dx),
        .dy      (s1_dy),
        .xen     (s1_xen),
        .xex     (s1_xex),
        .xden    (s1_xden),
        .yen     (s1_yen),
        .yex     (s1_yex),
        .yden    (s1_yden),
        .rej     (s1_rej),
        .bx_reg  (f_bx),
        .by_reg  (f_by),
        .nx1_reg (f_nx1),
        .ny1_reg (f_ny1),
        .nx2_reg (f_nx2),
        .ny2_reg (f_ny2),
        .neg_reg (f_neg),
        .d1_reg  (f_d1),
        .d2_reg  (f_d2),
        .rej_reg (f_rej)
    );

    // divider lanes
    logic [W+1:0] quo [4];
    logic [3:0]   nz;

    lsw_div #(.W(W)) u_div_x1 (
        .clk(clk), .en(en), .num(f_nx1), .den(f_d1), .quo(quo[0]), .rem_nz(nz[0]));
    lsw_div #(.W(W)) u_div_y1 (
        .clk(clk), .en(en), .num(f_ny1), .den(f_d1), .quo(quo[1]), .rem_nz(nz[1]));
    lsw_div #(.W(W)) u_div_x2 (
        .clk(clk), .en(en), .num(f_nx2), .den(f_d2), .quo(quo[2]), .rem_nz(nz[2]));
    lsw_div #(.W(W)) u_div_y2 (
        .clk(clk), .en(en), .num(f_ny2), .den(f_d2), .quo(quo[3]), .rem_nz(nz[3]));

    // sideband delayed alongside the dividers: rej, neg, bx, by
    logic [SW-1:0] side_reg [1:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= {f_rej, f_neg, f_bx, f_by};
            for (int k = 1; k < QW; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    logic                rej_d;
    logic [3:0]          neg_d;
    logic signed [W-1:0] bx_d, by_d;
    logic [W-1:0]        res [4];

    assign {rej_d, neg_d, bx_d, by_d} = side_reg[QW];

    // floor of the signed quotient, then add the base coordinate
    for (genvar i = 0; i < 4; i++)
    begin : g_res
        logic signed [W+2:0] mag;
        logic signed [W+2:0] qs;
        logic signed [W+2:0] sum;

        assign mag = $signed({1'b0, quo[i]}) + $signed((W+3)'(nz[i]));
        assign qs  = neg_d[i] ? -mag : $signed({1'b0, quo[i]});
        assign sum = qs + (W+3)'((i % 2 == 0) ? bx_d : by_d);
        assign res[i] = sum[W-1:0];
    end

    logic [DW-1:0] data_next;

    always_comb
    begin
        data_next = '0;
        if (!rej_d)
        begin
            data_next[4*W-1:0] = {res[3], res[2], res[1], res[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= data_next;
            m_axis_tuser <= !rej_d;
        end
    end

    a_hidden_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("rejected segment with nonzero coordinates");

    a_enter : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[1])
        else $error("accepted segment did not enter the pipeline");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

endmodule
